>>> rtl/iida_pkg.sv
// ----------------------------------------------------------------------------
// iida_pkg
// Types and constants shared by the indexed insert/delete array.
// ----------------------------------------------------------------------------
package iida_pkg;

	localparam int POS_W   = 5;
	localparam int VAL_W   = 32;
	localparam int CNTO_W  = 6;
	// wide enough for any index or count up to the largest depth
	localparam int CMP_W   = 7;

	localparam logic [1:0] REQ_INSERT   = 2'd0;
	localparam logic [1:0] REQ_DELETE   = 2'd1;
	localparam logic [1:0] REQ_TRAVERSE = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_BADPOS = 2'd2;
	localparam logic [1:0] STAT_EMPTY  = 2'd3;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INS,
		CMD_DEL,
		CMD_ROT
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t         cmd;
		logic [POS_W-1:0]  pos;
		logic [VAL_W-1:0]  value;
	} cell_ctl_t;

	typedef enum logic {
		S_IDLE,
		S_TRAV
	} fsm_state_t;

endpackage

>>> rtl/iida_if.sv
// ----------------------------------------------------------------------------
// iida_req_if / iida_res_if
// Valid/ready channels for requests and results of the array.
// ----------------------------------------------------------------------------
interface iida_req_if;
	import iida_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               req_type;
	logic [POS_W-1:0]         position;
	logic signed [VAL_W-1:0]  value;

	modport source (output valid, req_type, position, value, input ready);
	modport sink (input valid, req_type, position, value, output ready);
endinterface

interface iida_res_if;
	import iida_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [VAL_W-1:0]  value_res;
	logic [1:0]               status;
	logic [CNTO_W-1:0]        element_count;
	logic                     last;

	modport source (output valid, value_res, status, element_count, last, input ready);
	modport sink (input valid, value_res, status, element_count, last, output ready);
endinterface

>>> rtl/iida_cell.sv
// ----------------------------------------------------------------------------
// iida_cell
// One storage cell of the array: holds an entry and takes a neighbor's
// entry on insert, delete and traverse rotation.
// ----------------------------------------------------------------------------
module iida_cell
	import iida_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic              is_tail,
	input  logic [VAL_W-1:0]  left,
	input  logic [VAL_W-1:0]  right,
	input  logic [VAL_W-1:0]  first,
	output logic [VAL_W-1:0]  data
);

	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

	logic [VAL_W-1:0] data_q;
	logic [VAL_W-1:0] data_d;
	logic [CMP_W-1:0] pos_w;

	assign pos_w = CMP_W'(ctl.pos);

	always_comb begin
		data_d = data_q;
		unique case (ctl.cmd)
			CMD_HOLD: data_d = data_q;
			CMD_INS: begin
				if (MY_IDX == pos_w) begin
					data_d = ctl.value;
				end else if (MY_IDX > pos_w) begin
					data_d = left;
				end
			end
			CMD_DEL: begin
				if (MY_IDX >= pos_w) begin
					data_d = right;
				end
			end
			CMD_ROT: data_d = is_tail ? first : right;
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

>>> rtl/indexed_insert_delete_array.sv
// ----------------------------------------------------------------------------
// indexed_insert_delete_array
// Packed array of signed 32-bit entries with insert, delete and traverse.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready), results leave on res (valid/ready).
// An accepted insert or delete moves the row: every cell shifts toward or
// away from the position in parallel, and the single result beat is in the
// output register on the next cycle. An insert at a full array or past the
// count, or a delete at or past the count, answers with an error status and
// leaves the array alone. A traverse emits count beats, one per cycle, by
// rotating the cell row by one each beat and reading cell 0; the last beat
// has last set and the rotation leaves the row in its original order. An
// empty traverse answers with one beat of status empty. Request type 3 is
// dropped with no beat. Back-to-back inserts and deletes run at one per
// cycle; a traverse holds req.ready low until its last beat is produced.
// Reset clears the count and the output valid flag; cells and output data
// stay unknown until written. While res stalls, the output register holds
// its beat and no new request is taken nor traverse beat produced.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array
	import iida_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	iida_req_if.sink    req,
	iida_res_if.source  res
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	fsm_state_t        state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     rem_q, rem_d;

	logic              ov_q;
	logic [VAL_W-1:0]  ores_q;
	logic [1:0]        ostat_q;
	logic [CNTO_W-1:0] ocnt_q;
	logic              olast_q;

	logic              load;
	logic [VAL_W-1:0]  ld_res;
	logic [1:0]        ld_stat;
	logic [CW-1:0]     ld_cnt;
	logic              ld_last;

	cell_ctl_t         ctl;
	logic [VAL_W-1:0]  cell_d [DEPTH];
	logic [CW-1:0]     tail_idx;

	logic              slot_free;
	logic              acc;
	logic [CMP_W-1:0]  pos_w;
	logic [CMP_W-1:0]  cnt_w;
	logic [AW-1:0]     rd_idx;

	assign slot_free = !ov_q || res.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign acc       = req.valid && req.ready;
	assign pos_w     = CMP_W'(req.position);
	assign cnt_w     = CMP_W'(count_q);
	assign rd_idx    = AW'(pos_w);
	assign tail_idx  = count_q - CW'(1);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		rem_d       = rem_q;
		load        = 1'b0;
		ld_res      = '0;
		ld_stat     = STAT_OK;
		ld_cnt      = count_q;
		ld_last     = 1'b1;
		ctl.cmd     = CMD_HOLD;
		ctl.pos     = req.position;
		ctl.value   = req.value;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.req_type)
						REQ_INSERT: begin
							load = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								ld_stat = STAT_FULL;
							end else if (pos_w > cnt_w) begin
								ld_stat = STAT_BADPOS;
							end else begin
								ctl.cmd = CMD_INS;
								count_d = count_q + CW'(1);
								ld_cnt  = count_d;
							end
						end
						REQ_DELETE: begin
							load = 1'b1;
							if (pos_w >= cnt_w) begin
								ld_stat = STAT_BADPOS;
							end else begin
								ctl.cmd = CMD_DEL;
								ld_res  = cell_d[rd_idx];
								count_d = count_q - CW'(1);
								ld_cnt  = count_d;
							end
						end
						REQ_TRAVERSE: begin
							if (count_q == '0) begin
								load    = 1'b1;
								ld_stat = STAT_EMPTY;
							end else begin
								rem_d   = count_q;
								state_d = S_TRAV;
							end
						end
						default: ;
					endcase
				end
			end
			S_TRAV: begin
				if (slot_free) begin
					load    = 1'b1;
					ld_res  = cell_d[0];
					ld_last = (rem_q == CW'(1));
					ctl.cmd = CMD_ROT;
					rem_d   = rem_q - CW'(1);
					if (rem_q == CW'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rem_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ores_q  <= ld_res;
			ostat_q <= ld_stat;
			ocnt_q  <= CNTO_W'(ld_cnt);
			olast_q <= ld_last;
		end
	end

	// row of cells, each talking to its neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] left_w;
		logic [VAL_W-1:0] right_w;
		if (i == 0) begin : g_lo
			assign left_w = cell_d[0];
		end else begin : g_lo
			assign left_w = cell_d[i-1];
		end
		if (i == DEPTH - 1) begin : g_hi
			assign right_w = cell_d[i];
		end else begin : g_hi
			assign right_w = cell_d[i+1];
		end
		iida_cell #(
			.IDX(i)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.is_tail (tail_idx == CW'(i)),
			.left    (left_w),
			.right   (right_w),
			.first   (cell_d[0]),
			.data    (cell_d[i])
		);
	end

	assign res.valid         = ov_q;
	assign res.value_res     = ores_q;
	assign res.status        = ostat_q;
	assign res.element_count = ocnt_q;
	assign res.last          = olast_q;

endmodule

>>> sim/tb_indexed_insert_delete_array.sv
// ----------------------------------------------------------------------------
// tb_indexed_insert_delete_array
// Self-checking testbench for the indexed insert/delete array.
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the packed array and its fill
// level. It predicts the result beats of every accepted request and checks
// every result beat, field by field, in order. The run starts with a
// directed part covering empty, edge-position and extreme-value requests.
// It then runs random bursts: mixed traffic, fills to full and drains to
// empty. Both channels idle at random, and the result side is held off once
// for a long stretch.
// ----------------------------------------------------------------------------
module tb_indexed_insert_delete_array;
	import iida_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 32;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int ITEMS       = 410;
	localparam int HOLD_CYCLES = 200;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int MAX_REPORTS = 10;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct {
		logic signed [VAL_W-1:0] value_res;
		logic [1:0]              status;
		logic [CNTO_W-1:0]       element_count;
		logic                    last;
	} result_beat_t;

	class array_scoreboard;
		logic signed [VAL_W-1:0] cells [DEPTH];
		int                      fill;
		result_beat_t            expected_beats [$];
		int errors, beats_checked;
		int n_insert, n_delete, n_traverse, n_ignored, n_error_status;
		int n_full_seen, n_empty_seen;

		function new();
			fill = 0;
		endfunction

		function void push_beat(logic signed [VAL_W-1:0] v, logic [1:0] st, logic fin);
			result_beat_t b;
			b.value_res     = v;
			b.status        = st;
			b.element_count = CNTO_W'(fill);
			b.last          = fin;
			expected_beats.push_back(b);
			if (st != STAT_OK)
				n_error_status++;
		endfunction

		// called at the edge where the request beat is accepted
		function void note_request(logic [1:0] kind, logic [POS_W-1:0] pos,
				logic signed [VAL_W-1:0] val);
			logic signed [VAL_W-1:0] removed;
			case (kind)
				REQ_INSERT: begin
					n_insert++;
					if (fill >= DEPTH) begin
						push_beat('0, STAT_FULL, 1'b1);
					end else if (int'(pos) > fill) begin
						push_beat('0, STAT_BADPOS, 1'b1);
					end else begin
						for (int j = fill; j > int'(pos); j--)
							cells[IDX_W'(j)] = cells[IDX_W'(j-1)];
						cells[pos] = val;
						fill++;
						if (fill == DEPTH)
							n_full_seen++;
						push_beat('0, STAT_OK, 1'b1);
					end
				end
				REQ_DELETE: begin
					n_delete++;
					if (int'(pos) >= fill) begin
						push_beat('0, STAT_BADPOS, 1'b1);
					end else begin
						removed = cells[pos];
						for (int j = int'(pos); j + 1 < fill; j++)
							cells[IDX_W'(j)] = cells[IDX_W'(j+1)];
						fill--;
						if (fill == 0)
							n_empty_seen++;
						push_beat(removed, STAT_OK, 1'b1);
					end
				end
				REQ_TRAVERSE: begin
					n_traverse++;
					if (fill == 0)
						push_beat('0, STAT_EMPTY, 1'b1);
					else
						for (int j = 0; j < fill; j++)
							push_beat(cells[IDX_W'(j)], STAT_OK, j + 1 == fill);
				end
				default: n_ignored++;
			endcase
		endfunction

		function void check_beat(result_beat_t got);
			result_beat_t want;
			beats_checked++;
			if (expected_beats.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result beat %0d: value %0d status %0d count %0d last %0b",
						beats_checked, got.value_res, got.status, got.element_count, got.last);
				return;
			end
			want = expected_beats.pop_front();
			if (got.value_res !== want.value_res || got.status !== want.status ||
					got.element_count !== want.element_count || got.last !== want.last) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("mismatch on result beat %0d: expected value %0d status %0d count %0d last %0b",
						beats_checked, want.value_res, want.status, want.element_count,
						want.last);
					$display("  got value %0d status %0d count %0d last %0b",
						got.value_res, got.status, got.element_count, got.last);
				end
			end
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	iida_req_if req_ch ();
	iida_res_if res_ch ();

	indexed_insert_delete_array #(
		.DEPTH (DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	array_scoreboard sb;
	int  items_sent;
	int  cycles;
	bit  steady;
	bit  hold_off_req;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_INSERT;
		req_ch.position = '0;
		req_ch.value = '0;
		res_ch.ready = 1'b0;
		steady = 1'b0;
		hold_off_req = 1'b0;
		items_sent = 0;
		cycles = 0;
		sb = new();
	end

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycles, sb.pending());
			$display("indexed_insert_delete_array test failed");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 6);
		else
			return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		result_beat_t got;
		if (res_ch.valid && res_ch.ready) begin
			got.value_res     = res_ch.value_res;
			got.status        = res_ch.status;
			got.element_count = res_ch.element_count;
			got.last          = res_ch.last;
			sb.check_beat(got);
		end
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				res_ch.ready <= 1'b1;
			end else if (!steady && $urandom_range(0, 2) == 0) begin
				res_ch.ready <= 1'b0;
				repeat (pick_gap()) @(negedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_request(input logic [1:0] kind, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val);
		int gap;
		gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.position <= pos;
		req_ch.value    <= val;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(kind, pos, val);
		if (kind != REQ_UNUSED)
			items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_mixed(input int n);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				send_request(REQ_INSERT, (sb.fill < DEPTH) ? POS_W'($urandom_range(0, sb.fill))
					: POS_W'($urandom_range(0, DEPTH - 1)), pick_value());
			else if (r < 72)
				send_request(REQ_DELETE, (sb.fill > 0) ? POS_W'($urandom_range(0, sb.fill - 1))
					: POS_W'($urandom_range(0, DEPTH - 1)), $urandom);
			else if (r < 82)
				send_request(REQ_TRAVERSE, POS_W'($urandom), $urandom);
			else if (r < 97)
				// noise: positions anywhere, often out of range
				send_request($urandom_range(0, 1) ? REQ_DELETE : REQ_INSERT,
					POS_W'($urandom_range(0, DEPTH - 1)), pick_value());
			else
				send_request(REQ_UNUSED, POS_W'($urandom), $urandom);
		end
	endtask

	task automatic run_fill();
		while (sb.fill < DEPTH)
			send_request(REQ_INSERT, (sb.fill == DEPTH - 1) ? POS_W'(sb.fill)
				: POS_W'($urandom_range(0, sb.fill)), pick_value());
		send_request(REQ_INSERT, POS_W'($urandom), $urandom);
		send_request(REQ_TRAVERSE, POS_W'($urandom), $urandom);
	endtask

	task automatic run_drain();
		if (sb.fill > 0)
			send_request(REQ_DELETE, POS_W'(sb.fill - 1), $urandom);
		while (sb.fill > 0)
			send_request(REQ_DELETE, POS_W'($urandom_range(0, sb.fill - 1)), $urandom);
		send_request(REQ_DELETE, POS_W'($urandom), $urandom);
		send_request(REQ_TRAVERSE, POS_W'($urandom), $urandom);
	endtask

	initial begin
		int pick;
		#0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty array, edge positions, extreme values
		send_request(REQ_TRAVERSE, 5'd31, 32'sh7fff_ffff);
		send_request(REQ_DELETE, 5'd0, '0);
		send_request(REQ_DELETE, 5'd31, '0);
		send_request(REQ_INSERT, 5'd1, 32'sd5);
		send_request(REQ_INSERT, 5'd0, 32'sh8000_0000);
		send_request(REQ_INSERT, 5'd1, 32'sh7fff_ffff);
		send_request(REQ_INSERT, 5'd0, -32'sd1);
		send_request(REQ_INSERT, 5'd1, 32'sd0);
		send_request(REQ_UNUSED, 5'd31, 32'sh5a5a_a5a5);
		send_request(REQ_TRAVERSE, 5'd0, '0);
		send_request(REQ_DELETE, 5'd1, '0);
		send_request(REQ_DELETE, 5'd2, '0);
		send_request(REQ_DELETE, 5'd2, '0);
		send_request(REQ_INSERT, 5'd3, 32'sd99);
		send_request(REQ_INSERT, 5'd31, 32'sd99);
		send_request(REQ_TRAVERSE, 5'd31, -32'sd1);
		send_request(REQ_DELETE, 5'd0, '0);
		send_request(REQ_DELETE, 5'd0, '0);
		send_request(REQ_TRAVERSE, '0, '0);

		// sender pause until every result is back
		wait_drained();

		// long hold-off on results while requests keep coming back to back
		hold_off_req = 1'b1;
		steady = 1'b1;
		run_mixed(12);
		steady = 1'b0;

		run_fill();
		run_drain();

		while (items_sent < ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				run_mixed($urandom_range(10, 30));
			end else if (pick < 7) begin
				run_fill();
			end else if (pick < 9) begin
				run_drain();
			end else begin
				steady = 1'b1;
				run_mixed($urandom_range(10, 30));
				steady = 1'b0;
			end
			if ($urandom_range(0, 2) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (16) @(posedge clk);

		$display("covered %0d inserts, %0d deletes, %0d traverses, %0d ignored requests",
			sb.n_insert, sb.n_delete, sb.n_traverse, sb.n_ignored);
		$display("checked %0d result beats (%0d error status), full %0d times, emptied %0d times",
			sb.beats_checked, sb.n_error_status, sb.n_full_seen, sb.n_empty_seen);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("indexed_insert_delete_array test passed");
		else
			$display("indexed_insert_delete_array test failed");
		$finish;
	end

endmodule
